### rtl/query_language_lexer_top_defines.svh
// Assertion macros shared by the lexer modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef QUERY_LANGUAGE_LEXER_TOP_DEFINES_SVH
`define QUERY_LANGUAGE_LEXER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define QLL_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lexer assertion failed in %m");

// Consequence that must hold in the same cycle as the antecedent.
`define QLL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer assertion failed in %m");

// Consequence that must hold in the cycle after the antecedent.
`define QLL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer assertion failed in %m");

`endif

### rtl/qll_pkg.sv
package qll_pkg;

    // Field widths
    localparam int START_W = 32;
    localparam int KIND_W = 6;

    // Result queue sizing
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 6;
    localparam int QCNT_W = 3;

    // Keyword table sizing
    localparam int NKW = 13;
    localparam int KW_MAX = 10;
    localparam logic [3:0] ILEN_SAT = 4'd10;
    localparam logic [NKW-1:0] KW_ALL = '1;

    // Token kinds
    localparam logic [KIND_W-1:0] K_END = 6'd0;
    localparam logic [KIND_W-1:0] K_NUMBER = 6'd1;
    localparam logic [KIND_W-1:0] K_STRING = 6'd2;
    localparam logic [KIND_W-1:0] K_IDENT = 6'd3;
    localparam logic [KIND_W-1:0] K_DOT = 6'd16;
    localparam logic [KIND_W-1:0] K_COMMA = 6'd17;
    localparam logic [KIND_W-1:0] K_LPAREN = 6'd18;
    localparam logic [KIND_W-1:0] K_RPAREN = 6'd19;
    localparam logic [KIND_W-1:0] K_LBRACK = 6'd20;
    localparam logic [KIND_W-1:0] K_RBRACK = 6'd21;
    localparam logic [KIND_W-1:0] K_LBRACE = 6'd22;
    localparam logic [KIND_W-1:0] K_RBRACE = 6'd23;
    localparam logic [KIND_W-1:0] K_PLUS = 6'd24;
    localparam logic [KIND_W-1:0] K_MINUS = 6'd25;
    localparam logic [KIND_W-1:0] K_STAR = 6'd26;
    localparam logic [KIND_W-1:0] K_SLASH = 6'd27;
    localparam logic [KIND_W-1:0] K_EQ = 6'd28;
    localparam logic [KIND_W-1:0] K_NE = 6'd29;
    localparam logic [KIND_W-1:0] K_LT = 6'd30;
    localparam logic [KIND_W-1:0] K_LE = 6'd31;
    localparam logic [KIND_W-1:0] K_GT = 6'd32;
    localparam logic [KIND_W-1:0] K_GE = 6'd33;
    localparam logic [KIND_W-1:0] K_INVALID = 6'd34;

    // Characters with a special role
    localparam logic [7:0] CH_DOT = ".";
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACK = "[";
    localparam logic [7:0] CH_RBRACK = "]";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_PLUS = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_STAR = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_EQUALS = "=";
    localparam logic [7:0] CH_BANG = "!";
    localparam logic [7:0] CH_LESS = "<";
    localparam logic [7:0] CH_GREATER = ">";
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = "_";
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_N = "n";
    localparam logic [7:0] CH_T = "t";
    localparam logic [7:0] CH_R = "r";

    // Keyword spellings, lengths and kinds
    localparam logic [7:0] KW_SPELL [NKW][KW_MAX] = '{
        '{"a", "l", "l", 0, 0, 0, 0, 0, 0, 0},
        '{"f", "o", "r", "a", "l", "l", 0, 0, 0, 0},
        '{"a", "n", "y", 0, 0, 0, 0, 0, 0, 0},
        '{"e", "x", "i", "s", "t", "s", 0, 0, 0, 0},
        '{"n", "o", "n", "e", 0, 0, 0, 0, 0, 0},
        '{"i", "n", 0, 0, 0, 0, 0, 0, 0, 0},
        '{"w", "h", "e", "r", "e", 0, 0, 0, 0, 0},
        '{"s", "a", "t", "i", "s", "f", "i", "e", "s", 0},
        '{"a", "n", "d", 0, 0, 0, 0, 0, 0, 0},
        '{"o", "r", 0, 0, 0, 0, 0, 0, 0, 0},
        '{"n", "o", "t", 0, 0, 0, 0, 0, 0, 0},
        '{"t", "r", "u", "e", 0, 0, 0, 0, 0, 0},
        '{"f", "a", "l", "s", "e", 0, 0, 0, 0, 0}
    };
    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd3, 4'd6, 4'd3, 4'd6, 4'd4, 4'd2, 4'd5, 4'd9, 4'd3, 4'd2, 4'd3, 4'd4, 4'd5
    };
    localparam logic [KIND_W-1:0] KW_KIND [NKW] = '{
        6'd4, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15
    };

    // One input item as it enters the lexer core
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_input;
    } item_t;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [START_W-1:0] token_start;
        logic [7:0]         value_byte;
        logic               value_present;
        logic               token_last;
    } res_t;

    // Build a result item; the kind shows only on the last item of a run.
    function automatic res_t make_res(logic [KIND_W-1:0] kind, logic [START_W-1:0] start,
                                      logic [7:0] b, logic present, logic last);
        res_t r;
        r.token_kind = last ? kind : K_END;
        r.token_start = start;
        r.value_byte = present ? b : 8'h00;
        r.value_present = present;
        r.token_last = last;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_ident(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            CH_DOT:     k = K_DOT;
            CH_COMMA:   k = K_COMMA;
            CH_LPAREN:  k = K_LPAREN;
            CH_RPAREN:  k = K_RPAREN;
            CH_LBRACK:  k = K_LBRACK;
            CH_RBRACK:  k = K_RBRACK;
            CH_LBRACE:  k = K_LBRACE;
            CH_RBRACE:  k = K_RBRACE;
            CH_PLUS:    k = K_PLUS;
            CH_MINUS:   k = K_MINUS;
            CH_STAR:    k = K_STAR;
            CH_SLASH:   k = K_SLASH;
            CH_LESS:    k = K_LT;
            CH_GREATER: k = K_GT;
            default:    k = K_INVALID;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            CH_EQUALS: k = K_EQ;
            CH_BANG:   k = K_NE;
            CH_LESS:   k = K_LE;
            default:   k = K_GE;
        endcase
        return k;
    endfunction

    // Drop the keywords that cannot match once byte b sits at position idx.
    function automatic logic [NKW-1:0] kw_filter(logic [NKW-1:0] cand, logic [3:0] idx,
                                                 logic [7:0] b);
        logic [NKW-1:0] r;
        r = cand;
        for (int k = 0; k < NKW; k++) begin
            if (!((idx < KW_LEN[k]) && (KW_SPELL[k][idx] == b)))
                r[k] = 1'b0;
        end
        return r;
    endfunction

    // First keyword still in the running whose length matches, else identifier.
    function automatic logic [KIND_W-1:0] ident_kind(logic [NKW-1:0] cand, logic [3:0] len);
        logic [KIND_W-1:0] k;
        k = K_IDENT;
        for (int i = NKW - 1; i >= 0; i--) begin
            if (cand[i] && (KW_LEN[i] == len))
                k = KW_KIND[i];
        end
        return k;
    endfunction

endpackage

### rtl/query_language_lexer_top.sv
// Input items are held in the input register; result items go through a six-entry queue.
// Throughput: one input item per cycle while each produces at most one result and the
// output is not stalled; results leave one per cycle while m_tready is high.
// An item enters the lexer only with three queue entries free.
// Reset (rst_n low, asynchronous) empties the queue and input register and
// returns the lexer to idle between tokens at offset 0.
module query_language_lexer_top #(
    parameter int POS_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] token_start, [39:32] value_byte
    output logic [6:0]  m_tuser,   // [5:0] token_kind, [6] value_present
    output logic        m_tlast    // token_last
);

    logic                       in_valid_reg;
    qll_pkg::item_t             item_reg;
    logic                       fire;
    logic                       pop;
    qll_pkg::res_t              res [qll_pkg::MAX_RESULTS];
    logic [1:0]                 res_count;
    qll_pkg::res_t              head;
    logic [qll_pkg::QCNT_W-1:0] q_count;

    // The held item goes through the lexer once the queue has room for its results
    assign fire = in_valid_reg &&
                  (q_count <= qll_pkg::QCNT_W'(qll_pkg::QUEUE_DEPTH - qll_pkg::MAX_RESULTS));
    assign s_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data_byte <= s_tdata;
            item_reg.has_byte <= s_tuser[0];
            item_reg.end_of_input <= s_tlast;
        end
    end

    qll_core #(
        .POS_BITS(POS_BITS)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .fire(fire),
        .item(item_reg),
        .res(res),
        .res_count(res_count)
    );

    qll_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_data(res),
        .push_count(res_count),
        .pop(pop),
        .head(head),
        .count(q_count)
    );

    // Result side
    assign m_tvalid = (q_count != '0);
    assign pop = m_tvalid && m_tready;
    assign m_tdata = {head.value_byte, head.token_start};
    assign m_tuser = {head.value_present, head.token_kind};
    assign m_tlast = head.token_last;

endmodule

### rtl/qll_core.sv
`include "query_language_lexer_top_defines.svh"

module qll_core #(
    parameter int POS_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  qll_pkg::item_t item,
    output qll_pkg::res_t  res [qll_pkg::MAX_RESULTS],
    output logic [1:0]     res_count
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_INT,
        M_FRAC,
        M_STR,
        M_ESC,
        M_IDENT,
        M_OPER
    } mode_t;

    mode_t                         mode_reg, mode_next;
    logic                          qsingle_reg, qsingle_next;
    logic [7:0]                    held_reg, held_next;
    logic                          hvalid_reg, hvalid_next;
    logic [qll_pkg::START_W-1:0]   start_reg, start_next;
    logic [POS_BITS-1:0]           pos_reg, pos_next;
    logic [qll_pkg::NKW-1:0]       cand_reg, cand_next;
    logic [3:0]                    ilen_reg, ilen_next;

    logic [POS_BITS-1:0]           pos_inc;
    logic [POS_BITS-1:0]           pos_after;
    logic [qll_pkg::START_W-1:0]   pos_lo;
    logic [qll_pkg::START_W-1:0]   after_lo;

    // Saturating byte position, advanced by every byte taken
    assign pos_inc = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    assign pos_after = (fire && item.has_byte) ? pos_inc : pos_reg;

    // Token offsets are the low bits of the position, or the position zero-extended if narrower
    if (POS_BITS >= qll_pkg::START_W) begin : g_wide_pos
        assign pos_lo = pos_reg[qll_pkg::START_W-1:0];
        assign after_lo = pos_after[qll_pkg::START_W-1:0];
    end else begin : g_narrow_pos
        assign pos_lo = {{(qll_pkg::START_W - POS_BITS){1'b0}}, pos_reg};
        assign after_lo = {{(qll_pkg::START_W - POS_BITS){1'b0}}, pos_after};
    end

    // Lexer step: take the byte, start a new token if needed, then flush on end of input
    always_comb begin
        mode_t                       m;
        logic                        qs;
        logic [7:0]                  hb;
        logic                        hv;
        logic [qll_pkg::START_W-1:0] st;
        logic [qll_pkg::NKW-1:0]     c;
        logic [3:0]                  il;
        logic [1:0]                  n;
        logic [7:0]                  b;
        logic [7:0]                  q;
        logic [7:0]                  d;
        logic                        do_idle;
        logic                        do_feed;

        m = mode_reg;
        qs = qsingle_reg;
        hb = held_reg;
        hv = hvalid_reg;
        st = start_reg;
        c = cand_reg;
        il = ilen_reg;
        n = 2'd0;
        b = item.data_byte;
        q = qs ? qll_pkg::CH_SQUOTE : qll_pkg::CH_DQUOTE;
        d = b;
        do_idle = 1'b0;
        do_feed = 1'b0;
        for (int i = 0; i < qll_pkg::MAX_RESULTS; i++)
            res[i] = '0;

        if (fire && item.has_byte) begin
            // Continue or close the open token
            case (m)
                M_INT, M_FRAC: begin
                    if (qll_pkg::is_digit(b) || ((m == M_INT) && (b == qll_pkg::CH_DOT))) begin
                        res[n] = qll_pkg::make_res(qll_pkg::K_NUMBER, st, hb, 1'b1, 1'b0);
                        n = n + 2'd1;
                        if (b == qll_pkg::CH_DOT)
                            m = M_FRAC;
                        hb = b;
                    end else begin
                        res[n] = qll_pkg::make_res(qll_pkg::K_NUMBER, st, hb, 1'b1, 1'b1);
                        n = n + 2'd1;
                        hv = 1'b0;
                        m = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_STR: begin
                    if (b == q) begin
                        res[n] = qll_pkg::make_res(qll_pkg::K_STRING, st, hb, hv, 1'b1);
                        n = n + 2'd1;
                        hv = 1'b0;
                        m = M_IDLE;
                    end else if (b == qll_pkg::CH_BACKSLASH) begin
                        m = M_ESC;
                    end else begin
                        if (hv) begin
                            res[n] = qll_pkg::make_res(qll_pkg::K_STRING, st, hb, 1'b1, 1'b0);
                            n = n + 2'd1;
                        end
                        hb = b;
                        hv = 1'b1;
                    end
                end
                M_ESC: begin
                    if (b == qll_pkg::CH_N)
                        d = qll_pkg::CH_LF;
                    else if (b == qll_pkg::CH_T)
                        d = qll_pkg::CH_TAB;
                    else if (b == qll_pkg::CH_R)
                        d = qll_pkg::CH_CR;
                    if (hv) begin
                        res[n] = qll_pkg::make_res(qll_pkg::K_STRING, st, hb, 1'b1, 1'b0);
                        n = n + 2'd1;
                    end
                    hb = d;
                    hv = 1'b1;
                    m = M_STR;
                end
                M_IDENT: begin
                    if (qll_pkg::is_ident(b)) begin
                        res[n] = qll_pkg::make_res(qll_pkg::K_IDENT, st, hb, 1'b1, 1'b0);
                        n = n + 2'd1;
                        do_feed = 1'b1;
                        hb = b;
                    end else begin
                        res[n] = qll_pkg::make_res(qll_pkg::ident_kind(c, il), st, hb,
                                                   1'b1, 1'b1);
                        n = n + 2'd1;
                        hv = 1'b0;
                        m = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_OPER: begin
                    if (b == qll_pkg::CH_EQUALS) begin
                        res[n] = qll_pkg::make_res(qll_pkg::K_END, st, hb, 1'b1, 1'b0);
                        n = n + 2'd1;
                        res[n] = qll_pkg::make_res(qll_pkg::pair_kind(hb), st, b, 1'b1, 1'b1);
                        n = n + 2'd1;
                        hv = 1'b0;
                        m = M_IDLE;
                    end else begin
                        res[n] = qll_pkg::make_res(qll_pkg::single_kind(hb), st, hb,
                                                   1'b1, 1'b1);
                        n = n + 2'd1;
                        hv = 1'b0;
                        m = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                default: begin
                    m = M_IDLE;
                    do_idle = 1'b1;
                end
            endcase

            // Between tokens: classify the byte and open the next token
            if (do_idle) begin
                st = pos_lo;
                if (qll_pkg::is_space(b)) begin
                    m = M_IDLE;
                end else if (qll_pkg::is_digit(b)) begin
                    m = M_INT;
                    hb = b;
                    hv = 1'b1;
                end else if ((b == qll_pkg::CH_DQUOTE) || (b == qll_pkg::CH_SQUOTE)) begin
                    m = M_STR;
                    qs = (b == qll_pkg::CH_SQUOTE);
                    hv = 1'b0;
                end else if (qll_pkg::is_alpha(b) || (b == qll_pkg::CH_UNDERSCORE)) begin
                    m = M_IDENT;
                    c = qll_pkg::KW_ALL;
                    il = 4'd0;
                    do_feed = 1'b1;
                    hb = b;
                    hv = 1'b1;
                end else if ((b == qll_pkg::CH_EQUALS) || (b == qll_pkg::CH_BANG) ||
                             (b == qll_pkg::CH_LESS) || (b == qll_pkg::CH_GREATER)) begin
                    m = M_OPER;
                    hb = b;
                    hv = 1'b1;
                end else begin
                    res[n] = qll_pkg::make_res(qll_pkg::single_kind(b), st, b, 1'b1, 1'b1);
                    n = n + 2'd1;
                end
            end

            // Keyword matching advances by one character
            if (do_feed) begin
                c = qll_pkg::kw_filter(c, il, b);
                il = (il < qll_pkg::ILEN_SAT) ? il + 4'd1 : qll_pkg::ILEN_SAT;
            end
        end

        if (fire && item.end_of_input) begin
            // Close whatever token is still open
            case (m)
                M_INT, M_FRAC: begin
                    res[n] = qll_pkg::make_res(qll_pkg::K_NUMBER, st, hb, 1'b1, 1'b1);
                    n = n + 2'd1;
                end
                M_STR, M_ESC: begin
                    res[n] = qll_pkg::make_res(qll_pkg::K_STRING, st, hb, hv, 1'b1);
                    n = n + 2'd1;
                end
                M_IDENT: begin
                    res[n] = qll_pkg::make_res(qll_pkg::ident_kind(c, il), st, hb,
                                               1'b1, 1'b1);
                    n = n + 2'd1;
                end
                M_OPER: begin
                    res[n] = qll_pkg::make_res(qll_pkg::single_kind(hb), st, hb, 1'b1, 1'b1);
                    n = n + 2'd1;
                end
                default: begin
                    m = M_IDLE;
                end
            endcase

            // End token, then back to the state after reset
            res[n] = qll_pkg::make_res(qll_pkg::K_END, after_lo, 8'h00, 1'b0, 1'b1);
            n = n + 2'd1;
            m = M_IDLE;
            qs = 1'b0;
            hb = 8'h00;
            hv = 1'b0;
            st = '0;
            c = qll_pkg::KW_ALL;
            il = 4'd0;
        end

        mode_next = m;
        qsingle_next = qs;
        held_next = hb;
        hvalid_next = hv;
        start_next = st;
        cand_next = c;
        ilen_next = il;
        res_count = n;
    end

    assign pos_next = (fire && item.end_of_input) ? '0 : pos_after;

    // Lexer state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            qsingle_reg <= 1'b0;
            held_reg <= 8'h00;
            hvalid_reg <= 1'b0;
            start_reg <= '0;
            pos_reg <= '0;
            cand_reg <= qll_pkg::KW_ALL;
            ilen_reg <= 4'd0;
        end else begin
            mode_reg <= mode_next;
            qsingle_reg <= qsingle_next;
            held_reg <= held_next;
            hvalid_reg <= hvalid_next;
            start_reg <= start_next;
            pos_reg <= pos_next;
            cand_reg <= cand_next;
            ilen_reg <= ilen_next;
        end
    end

    // An end of input always yields the end token and leaves the lexer fresh
    `QLL_ASSERT_IMP(a_eoi_emits, fire && item.end_of_input, res_count != 2'd0)
    `QLL_ASSERT_NXT(a_eoi_fresh, fire && item.end_of_input, (mode_reg == M_IDLE) && (pos_reg == '0))

endmodule

### rtl/qll_queue.sv
`include "query_language_lexer_top_defines.svh"

module qll_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  qll_pkg::res_t              push_data [qll_pkg::MAX_RESULTS],
    input  logic [1:0]                 push_count,
    input  logic                       pop,
    output qll_pkg::res_t              head,
    output logic [qll_pkg::QCNT_W-1:0] count
);

    qll_pkg::res_t               entry_reg [qll_pkg::QUEUE_DEPTH];
    qll_pkg::res_t               entry_next [qll_pkg::QUEUE_DEPTH];
    logic [qll_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic [qll_pkg::QCNT_W-1:0]  base;
    logic [qll_pkg::QCNT_W-1:0]  top;

    // Entries shift towards the head on a pop; new items land behind the survivors
    assign base = count_reg - {{(qll_pkg::QCNT_W - 1){1'b0}}, pop};
    assign top = base + {1'b0, push_count};

    always_comb begin
        logic [qll_pkg::QCNT_W-1:0] slot;
        logic [qll_pkg::QCNT_W-1:0] off;
        for (int i = 0; i < qll_pkg::QUEUE_DEPTH; i++) begin
            slot = qll_pkg::QCNT_W'(i);
            off = slot - base;
            if ((slot >= base) && (slot < top))
                entry_next[i] = push_data[off[1:0]];
            else if (pop && (i + 1 < qll_pkg::QUEUE_DEPTH))
                entry_next[i] = entry_reg[(i + 1) % qll_pkg::QUEUE_DEPTH];
            else
                entry_next[i] = entry_reg[i];
        end
    end

    assign count_next = top;

    // Queue contents
    always_ff @(posedge clk) begin
        for (int i = 0; i < qll_pkg::QUEUE_DEPTH; i++)
            entry_reg[i] <= entry_next[i];
    end

    // Fill level
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign head = entry_reg[0];
    assign count = count_reg;

    // Fill level stays in range and tracks pushes and pops exactly
    `QLL_ASSERT(a_count_bound, count_reg <= qll_pkg::QCNT_W'(qll_pkg::QUEUE_DEPTH))
    `QLL_ASSERT_IMP(a_pop_nonempty, pop, count_reg != '0)
    `QLL_ASSERT_NXT(a_count_step, 1'b1, count_reg == $past(count_reg) - $past(pop) + $past(push_count))

endmodule

### tb/query_language_lexer_top_tb.sv
`timescale 1ns / 1ps

module query_language_lexer_top_tb;

    import qll_pkg::*;

    // Keyword kinds; the package only names the other token kinds.
    localparam logic [KIND_W-1:0] TK_ALL = 6'd4;
    localparam logic [KIND_W-1:0] TK_ANY = 6'd5;
    localparam logic [KIND_W-1:0] TK_EXISTS = 6'd6;
    localparam logic [KIND_W-1:0] TK_NONE = 6'd7;
    localparam logic [KIND_W-1:0] TK_IN = 6'd8;
    localparam logic [KIND_W-1:0] TK_WHERE = 6'd9;
    localparam logic [KIND_W-1:0] TK_SATISFIES = 6'd10;
    localparam logic [KIND_W-1:0] TK_AND = 6'd11;
    localparam logic [KIND_W-1:0] TK_OR = 6'd12;
    localparam logic [KIND_W-1:0] TK_NOT = 6'd13;
    localparam logic [KIND_W-1:0] TK_TRUE = 6'd14;
    localparam logic [KIND_W-1:0] TK_FALSE = 6'd15;

    localparam int IDLE_PCT = 26;
    localparam int RANDOM_ITEMS = 330;
    localparam int HOLD_AT = 150;
    localparam int HOLD_CYCLES = 64;
    localparam int CALM_FROM = 220;
    localparam int CALM_TO = 290;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [2:0] {
        LX_IDLE, LX_INT, LX_FRAC, LX_STR, LX_ESC, LX_IDENT, LX_OPER
    } lex_mode_e;

    // One source item, with an optional typed-in expectation.
    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       eoi;
        bit         fixed;
        bit         fixed_one;
        res_t       fixed_res;
    } src_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [6:0]  m_tuser;
    logic        m_tlast;

    query_language_lexer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    string kw_words [13] = '{"all", "forall", "any", "exists", "none", "in", "where",
                             "satisfies", "and", "or", "not", "true", "false"};
    logic [KIND_W-1:0] kw_kinds [13] = '{TK_ALL, TK_ALL, TK_ANY, TK_EXISTS, TK_NONE,
                                         TK_IN, TK_WHERE, TK_SATISFIES, TK_AND, TK_OR,
                                         TK_NOT, TK_TRUE, TK_FALSE};

    // Directed source text. Only the first rows carry a typed-in result.
    src_item_t directed_rows [25] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, {K_END, 32'd0, 8'h00, 1'b0, 1'b1}},
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 48'd0},
        '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, {K_INVALID, 32'd0, 8'h00, 1'b1, 1'b1}},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, {K_INVALID, 32'd1, 8'hFF, 1'b1, 1'b1}},
        '{CH_EQUALS, 1'b1, 1'b0, 1'b1, 1'b0, 48'd0},
        '{"i", 1'b1, 1'b0, 1'b1, 1'b1, {K_INVALID, 32'd2, CH_EQUALS, 1'b1, 1'b1}},
        '{"n", 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_LESS, 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_EQUALS, 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{"9", 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_DOT, 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{"5", 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_DQUOTE, 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_DQUOTE, 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_SPACE, 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_SQUOTE, 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_BACKSLASH, 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_T, 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{"q", 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_BACKSLASH, 1'b1, 1'b1, 1'b0, 1'b0, 48'd0},
        '{"w", 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{"h", 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 48'd0},
        '{CH_GREATER, 1'b1, 1'b0, 1'b0, 1'b0, 48'd0},
        '{"x", 1'b1, 1'b1, 1'b0, 1'b0, 48'd0}
    };

    src_item_t source_items [$];
    res_t      expected_tokens [$];
    res_t      predicted_now [$];
    src_item_t offered;

    // Predicted lexer state.
    lex_mode_e          mode;
    bit                 single_q;
    logic [7:0]         held;
    bit                 held_ok;
    logic [START_W-1:0] tok_start;
    logic [START_W-1:0] pos;
    logic [NKW-1:0]     kw_live;
    logic [3:0]         id_len;

    bit in_taken;
    bit calm;
    bit hold_off;
    int items_in;
    int results_seen;
    int texts;
    int mismatches;
    int gen_count;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #400_000;
        $display("Timed out with %0d result items outstanding.", expected_tokens.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bit digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit word_ch(logic [7:0] c);
        return letter_ch(c) || digit_ch(c) || c == CH_UNDERSCORE;
    endfunction

    function automatic bit blank_ch(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(logic [7:0] c);
        case (c)
            CH_DOT:     return K_DOT;
            CH_COMMA:   return K_COMMA;
            CH_LPAREN:  return K_LPAREN;
            CH_RPAREN:  return K_RPAREN;
            CH_LBRACK:  return K_LBRACK;
            CH_RBRACK:  return K_RBRACK;
            CH_LBRACE:  return K_LBRACE;
            CH_RBRACE:  return K_RBRACE;
            CH_PLUS:    return K_PLUS;
            CH_MINUS:   return K_MINUS;
            CH_STAR:    return K_STAR;
            CH_SLASH:   return K_SLASH;
            CH_LESS:    return K_LT;
            CH_GREATER: return K_GT;
            default:    return K_INVALID;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] paired_kind(logic [7:0] c);
        case (c)
            CH_EQUALS: return K_EQ;
            CH_BANG:   return K_NE;
            CH_LESS:   return K_LE;
            default:   return K_GE;
        endcase
    endfunction

    // Token kind of the identifier collected so far.
    function automatic logic [KIND_W-1:0] word_kind();
        for (int k = 0; k < NKW; k++)
            if (kw_live[k] && kw_words[k].len() == id_len)
                return kw_kinds[k];
        return K_IDENT;
    endfunction

    task automatic put_token_item(logic [KIND_W-1:0] kind, logic [7:0] b, bit present,
                                  bit last);
        res_t r;
        r.token_kind = last ? kind : K_END;
        r.token_start = tok_start;
        r.value_byte = present ? b : 8'h00;
        r.value_present = present;
        r.token_last = last;
        predicted_now.push_back(r);
    endtask

    task automatic lex_clear();
        mode = LX_IDLE;
        single_q = 1'b0;
        held = 8'h00;
        held_ok = 1'b0;
        tok_start = '0;
        pos = '0;
        kw_live = '1;
        id_len = 4'd0;
    endtask

    // Narrow the keyword candidates by one more identifier byte.
    task automatic kw_step(logic [7:0] b);
        for (int k = 0; k < NKW; k++)
            if (kw_live[k] && (id_len >= kw_words[k].len() || kw_words[k][id_len] != b))
                kw_live[k] = 1'b0;
        id_len = (id_len < ILEN_SAT) ? id_len + 4'd1 : ILEN_SAT;
    endtask

    task automatic close_quote();
        if (held_ok)
            put_token_item(K_STRING, held, 1'b1, 1'b1);
        else
            put_token_item(K_STRING, 8'h00, 1'b0, 1'b1);
        held_ok = 1'b0;
        mode = LX_IDLE;
    endtask

    // A byte seen between tokens opens the next token.
    task automatic lex_start(logic [7:0] b);
        tok_start = pos;
        if (blank_ch(b))
            return;
        if (digit_ch(b))
        begin
            mode = LX_INT;
            held = b;
            held_ok = 1'b1;
        end
        else if (b == CH_DQUOTE || b == CH_SQUOTE)
        begin
            mode = LX_STR;
            single_q = (b == CH_SQUOTE);
            held_ok = 1'b0;
        end
        else if (letter_ch(b) || b == CH_UNDERSCORE)
        begin
            mode = LX_IDENT;
            kw_live = '1;
            id_len = 4'd0;
            kw_step(b);
            held = b;
            held_ok = 1'b1;
        end
        else if (b == CH_EQUALS || b == CH_BANG || b == CH_LESS || b == CH_GREATER)
        begin
            mode = LX_OPER;
            held = b;
            held_ok = 1'b1;
        end
        else
            put_token_item(punct_kind(b), b, 1'b1, 1'b1);
    endtask

    task automatic lex_byte(logic [7:0] b);
        logic [7:0] q;
        logic [7:0] d;
        q = single_q ? CH_SQUOTE : CH_DQUOTE;
        case (mode)
            LX_INT, LX_FRAC:
            begin
                if (digit_ch(b) || (mode == LX_INT && b == CH_DOT))
                begin
                    put_token_item(K_NUMBER, held, 1'b1, 1'b0);
                    if (b == CH_DOT)
                        mode = LX_FRAC;
                    held = b;
                end
                else
                begin
                    put_token_item(K_NUMBER, held, 1'b1, 1'b1);
                    held_ok = 1'b0;
                    mode = LX_IDLE;
                    lex_start(b);
                end
            end
            LX_STR:
            begin
                if (b == q)
                    close_quote();
                else if (b == CH_BACKSLASH)
                    mode = LX_ESC;
                else
                begin
                    if (held_ok)
                        put_token_item(K_STRING, held, 1'b1, 1'b0);
                    held = b;
                    held_ok = 1'b1;
                end
            end
            LX_ESC:
            begin
                d = (b == CH_N) ? CH_LF : (b == CH_T) ? CH_TAB : (b == CH_R) ? CH_CR : b;
                if (held_ok)
                    put_token_item(K_STRING, held, 1'b1, 1'b0);
                held = d;
                held_ok = 1'b1;
                mode = LX_STR;
            end
            LX_IDENT:
            begin
                if (word_ch(b))
                begin
                    put_token_item(K_IDENT, held, 1'b1, 1'b0);
                    kw_step(b);
                    held = b;
                end
                else
                begin
                    put_token_item(word_kind(), held, 1'b1, 1'b1);
                    held_ok = 1'b0;
                    mode = LX_IDLE;
                    lex_start(b);
                end
            end
            LX_OPER:
            begin
                if (b == CH_EQUALS)
                begin
                    put_token_item(K_END, held, 1'b1, 1'b0);
                    put_token_item(paired_kind(held), b, 1'b1, 1'b1);
                    held_ok = 1'b0;
                    mode = LX_IDLE;
                end
                else
                begin
                    put_token_item(punct_kind(held), held, 1'b1, 1'b1);
                    held_ok = 1'b0;
                    mode = LX_IDLE;
                    lex_start(b);
                end
            end
            default:
            begin
                mode = LX_IDLE;
                lex_start(b);
            end
        endcase
    endtask

    // Predict the result items of one accepted source item.
    task automatic lex_item(logic [7:0] b, logic has, logic eoi);
        predicted_now.delete();
        if (has)
        begin
            lex_byte(b);
            if (pos != '1)
                pos = pos + 1'b1;
        end
        if (eoi)
        begin
            case (mode)
                LX_INT, LX_FRAC: put_token_item(K_NUMBER, held, 1'b1, 1'b1);
                LX_STR, LX_ESC:  close_quote();
                LX_IDENT:        put_token_item(word_kind(), held, 1'b1, 1'b1);
                LX_OPER:         put_token_item(punct_kind(held), held, 1'b1, 1'b1);
                default:         ;
            endcase
            tok_start = pos;
            put_token_item(K_END, 8'h00, 1'b0, 1'b1);
            lex_clear();
        end
    endtask

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Source text generation.
    task automatic add_raw(logic [7:0] b, logic has, logic eoi);
        src_item_t it;
        it.data = b;
        it.has = has;
        it.eoi = eoi;
        it.fixed = 1'b0;
        it.fixed_one = 1'b0;
        it.fixed_res = '0;
        source_items.push_back(it);
        if (has || eoi)
            gen_count++;
    endtask

    task automatic add_char(logic [7:0] b);
        add_raw(b, 1'b1, 1'b0);
    endtask

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 3))
            0:       return "a" + 8'($urandom_range(0, 25));
            1:       return "A" + 8'($urandom_range(0, 25));
            2:       return "0" + 8'($urandom_range(0, 9));
            default: return CH_UNDERSCORE;
        endcase
    endfunction

    task automatic add_blanks(int n);
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 3))
                0:       add_char(CH_SPACE);
                1:       add_char(CH_TAB);
                2:       add_char(CH_LF);
                default: add_char(CH_CR);
            endcase
    endtask

    // A keyword, now and then cut short or run on into an identifier.
    task automatic add_keyword();
        int k;
        int n;
        k = $urandom_range(0, NKW - 1);
        n = kw_words[k].len();
        if ($urandom_range(99) < 10)
            n = n - 1;
        for (int i = 0; i < n; i++)
            add_char(kw_words[k][i]);
        if ($urandom_range(99) < 20)
            add_char(rand_word_char());
    endtask

    task automatic add_ident();
        int n;
        n = $urandom_range(1, 12);
        add_char(($urandom_range(0, 4) == 0) ? CH_UNDERSCORE : "a" + 8'($urandom_range(0, 25)));
        for (int i = 1; i < n; i++)
            add_char(rand_word_char());
    endtask

    task automatic add_number();
        for (int i = $urandom_range(1, 4); i > 0; i--)
            add_char("0" + 8'($urandom_range(0, 9)));
        if ($urandom_range(99) < 60)
        begin
            add_char(CH_DOT);
            for (int i = $urandom_range(0, 3); i > 0; i--)
                add_char("0" + 8'($urandom_range(0, 9)));
            if ($urandom_range(99) < 10)
                add_char(CH_DOT);
        end
    endtask

    // A quoted string; an unterminated one has to end the text.
    task automatic add_string(output bit left_open);
        logic [7:0] q;
        logic [7:0] other;
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        other = (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
        add_char(q);
        for (int i = $urandom_range(0, 5); i > 0; i--)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    add_char(CH_BACKSLASH);
                    case ($urandom_range(0, 6))
                        0:       add_char(CH_N);
                        1:       add_char(CH_T);
                        2:       add_char(CH_R);
                        3:       add_char(q);
                        4:       add_char(other);
                        5:       add_char(CH_BACKSLASH);
                        default: add_char(8'($urandom_range(0, 255)));
                    endcase
                end
                2:       add_char(other);
                3:       add_char(8'($urandom_range(0, 255)));
                default: add_char(8'($urandom_range(32, 126)));
            endcase
        end
        left_open = ($urandom_range(99) < 15);
        if (!left_open)
            add_char(q);
        else if ($urandom_range(99) < 40)
            add_char(CH_BACKSLASH);
    endtask

    task automatic add_operator();
        string ops;
        ops = "=!<>.,()[]{}+-*/";
        add_char(ops[$urandom_range(0, ops.len() - 1)]);
        if ($urandom_range(99) < 40)
            add_char(CH_EQUALS);
    endtask

    // One source text: a few tokens, then the end of input.
    task automatic build_text();
        int ntok;
        bit left_open;
        ntok = $urandom_range(1, 6);
        left_open = 1'b0;
        for (int t = 0; t < ntok && !left_open; t++)
        begin
            if ($urandom_range(99) < 60)
                add_blanks($urandom_range(1, 2));
            case ($urandom_range(0, 11))
                0, 1, 2: add_keyword();
                3:       add_ident();
                4, 5:    add_number();
                6, 7:    add_string(left_open);
                8, 9:    add_operator();
                10:      add_char(8'($urandom_range(0, 255)));
                default: add_raw(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            endcase
        end
        if ($urandom_range(99) < 60 && source_items[source_items.size() - 1].has)
            source_items[source_items.size() - 1].eoi = 1'b1;
        else
            add_raw(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        texts++;
    endtask

    // Sender: offers the next item at the falling edge, idling at random except while calm.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (source_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    offered = source_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= offered.data;
                    s_tuser <= offered.has;
                    s_tlast <= offered.eoi;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random, always while held off, and not at all while calm.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // One long hold-off on the result side so that the queue fills.
    initial
    begin
        hold_off = 1'b0;
        wait (items_in >= HOLD_AT);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Monitor: predicts at each accepted item and checks each result item.
    always @(posedge clk)
    begin
        res_t want;
        in_taken = s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            lex_item(offered.data, offered.has, offered.eoi);
            if (offered.fixed)
            begin
                if (offered.fixed_one)
                    expected_tokens.push_back(offered.fixed_res);
            end
            else
                foreach (predicted_now[i])
                    expected_tokens.push_back(predicted_now[i]);
            items_in++;
            calm = (items_in >= CALM_FROM && items_in < CALM_TO);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_tokens.size() == 0)
                report_mismatch("result item with nothing expected",
                                {m_tuser[5:0], m_tdata[31:0], m_tdata[39:32], m_tuser[6],
                                 m_tlast}, 48'd0);
            else
            begin
                want = expected_tokens.pop_front();
                if (m_tuser[5:0] !== want.token_kind)
                    report_mismatch("token_kind", m_tuser[5:0], want.token_kind);
                if (m_tdata[31:0] !== want.token_start)
                    report_mismatch("token_start", m_tdata[31:0], want.token_start);
                if (m_tdata[39:32] !== want.value_byte)
                    report_mismatch("value_byte", m_tdata[39:32], want.value_byte);
                if (m_tuser[6] !== want.value_present)
                    report_mismatch("value_present", m_tuser[6], want.value_present);
                if (m_tlast !== want.token_last)
                    report_mismatch("token_last", m_tlast, want.token_last);
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        in_taken = 1'b0;
        calm = 1'b0;
        items_in = 0;
        results_seen = 0;
        texts = 0;
        mismatches = 0;
        gen_count = 0;
        lex_clear();

        // Directed rows first, then random texts.
        foreach (directed_rows[i])
            source_items.push_back(directed_rows[i]);
        while (gen_count < RANDOM_ITEMS)
            build_text();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go in and every result item to come out.
        @(negedge clk);
        while (source_items.size() != 0 || s_tvalid || expected_tokens.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_tokens.size() != 0)
            report_mismatch("result items never delivered", expected_tokens.size(), 48'd0);
        $display("Fed %0d source items over %0d directed rows and %0d random texts.",
                 items_in, $size(directed_rows), texts);
        $display("Checked %0d result items; %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### query_language_lexer_top.f
+incdir+rtl
rtl/qll_pkg.sv
rtl/qll_core.sv
rtl/qll_queue.sv
rtl/query_language_lexer_top.sv
tb/query_language_lexer_top_tb.sv
